FILE: sv/tobqc_pkg.sv
package tobqc_pkg;

  typedef enum logic [1:0] {
    CMD_BOOK  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_APPLIED   = 3'd0,
    ST_FILTERED  = 3'd1,
    ST_STALE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD       = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  localparam logic [1:0] SIDE_BUY  = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        instr_key;
    logic [1:0]         side;
    logic signed [31:0] level_count;
    logic signed [63:0] price;
    logic signed [63:0] quantity;
    logic signed [63:0] order_count;
    logic signed [63:0] tick_bid;
    logic signed [63:0] tick_ask;
    logic signed [63:0] tick_last;
    logic signed [63:0] volume;
    logic [63:0]        timestamp;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        quote_valid;
    logic [62:0] bid_out;
    logic [62:0] ask_out;
    logic [62:0] mid_out;
    logic [62:0] spread_out;
    logic [63:0] ts_out;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        early;      // result already decided, no table access
    logic [2:0]  early_status;
    logic [1:0]  cmd;
    logic        sell;
    logic [63:0] key;
    logic [62:0] p0;         // book price or tick bid
    logic [62:0] p1;         // tick ask
    logic [63:0] ts;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_READ,
    BK_EXEC,
    BK_QUOTE
  } bk_state_e;

endpackage

FILE: sv/tobqc_front.sv
module tobqc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tobqc_pkg::in_item_t  item_i,
  output logic                 busy_o,
  output logic                 push_valid_o,
  output tobqc_pkg::job_t      push_job_o,
  input  logic                 push_ready_i
);
  tobqc_pkg::in_item_t item;
  tobqc_pkg::job_t     job;
  logic                full_q;
  tobqc_pkg::job_t     job_q;
  logic                bad_book, filt_book, bad_tick, filt_tick;

  assign item = item_i;

  always_comb begin
    bad_book  = item.instr_key == 64'd0 || item.timestamp == 64'd0 || item.side[1];
    filt_book = item.level_count <= 32'sd0 || item.price <= 64'sd0 ||
                item.quantity <= 64'sd0 || item.order_count <= 64'sd0;
    bad_tick  = item.instr_key == 64'd0 || item.timestamp == 64'd0;
    filt_tick = item.tick_bid <= 64'sd0 || item.tick_ask <= 64'sd0 ||
                item.tick_last <= 64'sd0 || item.volume < 64'sd0;
    job.cmd  = item.cmd;
    job.sell = item.side == tobqc_pkg::SIDE_SELL;
    job.key  = item.instr_key;
    job.ts   = item.timestamp;
    job.p0   = (item.cmd == tobqc_pkg::CMD_TICK) ? item.tick_bid[62:0] : item.price[62:0];
    job.p1   = item.tick_ask[62:0];
    job.early = 1'b0;
    job.early_status = tobqc_pkg::ST_APPLIED;
    case (tobqc_pkg::cmd_e'(item.cmd))
      tobqc_pkg::CMD_BOOK: begin
        if (bad_book) begin
          job.early = 1'b1; job.early_status = tobqc_pkg::ST_BAD;
        end else if (filt_book) begin
          job.early = 1'b1; job.early_status = tobqc_pkg::ST_FILTERED;
        end
      end
      tobqc_pkg::CMD_TICK: begin
        if (bad_tick) begin
          job.early = 1'b1; job.early_status = tobqc_pkg::ST_BAD;
        end else if (filt_tick) begin
          job.early = 1'b1; job.early_status = tobqc_pkg::ST_FILTERED;
        end
      end
      tobqc_pkg::CMD_QUERY: ;
      default: begin
        job.early = 1'b1; job.early_status = tobqc_pkg::ST_BAD;
      end
    endcase
  end

  // one-entry queue between front and back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (start_i && !busy_o) begin
      full_q <= 1'b1;
    end else if (push_ready_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) job_q <= job;
  end

  assign busy_o       = full_q;
  assign push_valid_o = full_q;
  assign push_job_o   = job_q;

endmodule

FILE: sv/tobqc_back.sv
module tobqc_back #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [62:0]          max_notional_i,
  input  logic                 job_valid_i,
  input  tobqc_pkg::job_t      job_i,
  output logic                 job_ready_o,
  output logic                 done_o,
  output tobqc_pkg::out_item_t result_o
);
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  logic [63:0] key_mem [TABLE_ENTRIES];
  logic [62:0] bid_mem [TABLE_ENTRIES];
  logic [62:0] ask_mem [TABLE_ENTRIES];
  logic [63:0] ts_mem  [TABLE_ENTRIES];
  logic [1:0]  flg_mem [TABLE_ENTRIES];

  tobqc_pkg::bk_state_e state_q, state_d;
  tobqc_pkg::job_t      job_q;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [63:0]          rkey_q;
  logic [62:0]          rbid_q, rask_q;
  logic [63:0]          rts_q;
  logic [1:0]           rflg_q;
  logic                 fresh_q, fresh_d;
  logic                 done_q, done_d;
  tobqc_pkg::out_item_t res_q, res_d;
  logic                 wr_en, wr_key;
  logic [62:0]          w_bid, w_ask, spread, a_v, b_v;
  logic [63:0]          w_ts;
  logic [1:0]           w_flg;
  logic                 newer, valid_q, qok;
  logic [62:0]          sprd_q;

  // registered reads of all stores at the scan index
  always_ff @(posedge clk_i) begin
    rkey_q <= key_mem[idx_q[AW-1:0]];
    rbid_q <= bid_mem[idx_q[AW-1:0]];
    rask_q <= ask_mem[idx_q[AW-1:0]];
    rts_q  <= ts_mem[idx_q[AW-1:0]];
    rflg_q <= flg_mem[idx_q[AW-1:0]];
    if (wr_key) key_mem[idx_q[AW-1:0]] <= job_q.key;
    if (wr_en) begin
      bid_mem[idx_q[AW-1:0]] <= w_bid;
      ask_mem[idx_q[AW-1:0]] <= w_ask;
      ts_mem[idx_q[AW-1:0]]  <= w_ts;
      flg_mem[idx_q[AW-1:0]] <= w_flg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tobqc_pkg::BK_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    fresh_q <= fresh_d;
    res_q   <= res_d;
    if (job_valid_i && job_ready_o) job_q <= job_i;
    sprd_q  <= rask_q - rbid_q;
    valid_q <= qok;
  end

  always_comb begin
    qok = rflg_q == 2'b11 && rbid_q != '0 && rask_q != '0 && rask_q >= rbid_q &&
          rbid_q <= max_notional_i && rask_q <= max_notional_i;
    a_v = rask_q; b_v = rbid_q;
    spread = sprd_q;
    newer = (fresh_q ? 1'b1 : (rts_q == 64'd0 || job_q.ts > rts_q));
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    fresh_d = fresh_q;
    done_d  = 1'b0;
    res_d   = res_q;
    wr_en   = 1'b0;
    wr_key  = 1'b0;
    w_bid = fresh_q ? '0 : rbid_q;
    w_ask = fresh_q ? '0 : rask_q;
    w_ts  = job_q.ts;
    w_flg = fresh_q ? 2'b00 : rflg_q;
    job_ready_o = state_q == tobqc_pkg::BK_IDLE;
    case (state_q)
      tobqc_pkg::BK_IDLE: begin
        idx_d = '0;
        fresh_d = 1'b0;
        if (job_valid_i) begin
          if (job_i.early) begin
            res_d = '0;
            res_d.status = job_i.early_status;
            done_d = 1'b1;
          end else begin
            state_d = tobqc_pkg::BK_SEARCH;
          end
        end
      end
      // one key per BK_SEARCH/BK_READ pair: idx_q is presented here, the read lands in BK_READ
      tobqc_pkg::BK_SEARCH: begin
        if (idx_q >= cnt_q) begin
          res_d = '0;
          if (job_q.cmd == tobqc_pkg::CMD_QUERY) begin
            res_d.status = tobqc_pkg::ST_NOT_FOUND;
            done_d = 1'b1; state_d = tobqc_pkg::BK_IDLE;
          end else if (cnt_q == FULL_CNT) begin
            res_d.status = tobqc_pkg::ST_FULL;
            done_d = 1'b1; state_d = tobqc_pkg::BK_IDLE;
          end else begin
            fresh_d = 1'b1;
            wr_key  = 1'b1;
            cnt_d   = cnt_q + 1'b1;
            state_d = tobqc_pkg::BK_EXEC;
          end
        end else begin
          state_d = tobqc_pkg::BK_READ;
        end
      end
      tobqc_pkg::BK_READ: begin
        if (rkey_q == job_q.key) begin
          state_d = (job_q.cmd == tobqc_pkg::CMD_QUERY) ? tobqc_pkg::BK_QUOTE
                                                        : tobqc_pkg::BK_EXEC;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = tobqc_pkg::BK_SEARCH;
        end
      end
      tobqc_pkg::BK_EXEC: begin
        res_d = '0;
        res_d.status = tobqc_pkg::ST_APPLIED;
        if (!newer) begin
          res_d.status = tobqc_pkg::ST_STALE;
        end else if (job_q.cmd == tobqc_pkg::CMD_TICK) begin
          w_bid = job_q.p0; w_ask = job_q.p1; w_flg = 2'b11; wr_en = 1'b1;
        end else if (!job_q.sell) begin
          if (fresh_q || !rflg_q[0] || job_q.p0 > rbid_q) begin
            w_bid = job_q.p0; w_flg[0] = 1'b1; wr_en = 1'b1;
          end else begin
            res_d.status = tobqc_pkg::ST_STALE;
          end
        end else begin
          if (fresh_q || !rflg_q[1] || job_q.p0 < rask_q) begin
            w_ask = job_q.p0; w_flg[1] = 1'b1; wr_en = 1'b1;
          end else begin
            res_d.status = tobqc_pkg::ST_STALE;
          end
        end
        done_d = 1'b1;
        state_d = tobqc_pkg::BK_IDLE;
      end
      tobqc_pkg::BK_QUOTE: begin
        res_d = '0;
        res_d.status = tobqc_pkg::ST_APPLIED;
        res_d.bid_out = b_v;
        res_d.ask_out = a_v;
        res_d.ts_out  = rts_q;
        if (valid_q) begin
          res_d.quote_valid = 1'b1;
          res_d.spread_out  = spread;
          res_d.mid_out     = b_v + (spread >> 1);
        end
        done_d = 1'b1;
        state_d = tobqc_pkg::BK_IDLE;
      end
      default: state_d = tobqc_pkg::BK_IDLE;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT) else $error("entry count overflow");
  a_grow_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != $past(cnt_q) |-> cnt_q == $past(cnt_q) + 1'b1) else $error("count jump");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == tobqc_pkg::BK_IDLE) else $error("done while busy");
  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == tobqc_pkg::BK_EXEC) else $error("stray write");

endmodule

FILE: sv/top_of_book_quote_cache.sv
// rejected items are answered from the back end's idle state without touching the table;
// all other items take the table scan through the registered read port, one
// BK_SEARCH/BK_READ pair per probed entry, so a miss probes every stored entry
// one item is in flight in the back end while one more waits in the queue
// reset clears the entry count, state and max_notional (to all ones); tables are not cleared
// results are strobed on done_o for one cycle, the receiver cannot stall
module top_of_book_quote_cache #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  tobqc_pkg::in_item_t  item_i,
  output logic                 busy_o,
  input  logic                 cfg_we_i,
  input  logic [62:0]          cfg_wdata_i,
  output logic                 done_o,
  output tobqc_pkg::out_item_t result_o
);
  logic [62:0]     max_notional_q;
  logic            job_valid, job_ready;
  tobqc_pkg::job_t job;

  // notional limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_notional_q <= '1;
    end else if (cfg_we_i) begin
      max_notional_q <= cfg_wdata_i;
    end
  end

  // front: validate and classify, hold in a one-deep queue
  tobqc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .item_i       (item_i),
    .busy_o       (busy_o),
    .push_valid_o (job_valid),
    .push_job_o   (job),
    .push_ready_i (job_ready)
  );

  // back: table scan, update and quote forming
  tobqc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_notional_i (max_notional_q),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_ready_o    (job_ready),
    .done_o         (done_o),
    .result_o       (result_o)
  );

endmodule

FILE: tb/top_of_book_quote_cache_tb.sv
module top_of_book_quote_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam logic [62:0] MASK63 = {63{1'b1}};
  // settle margin covers a miss that scans the whole table
  localparam int unsigned SETTLE_CYCLES = 2 * TABLE_ENTRIES + 40;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  tobqc_pkg::in_item_t item_i = '0;
  logic busy_o;
  logic cfg_we_i = 1'b0;
  logic [62:0] cfg_wdata_i = '0;
  logic done_o;
  tobqc_pkg::out_item_t result_o;

  always #6 clk_i = ~clk_i;

  top_of_book_quote_cache #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_o(busy_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o), .result_o(result_o)
  );

  // predictor copy of the quote table
  logic [63:0] inst_keys[TABLE_ENTRIES];
  logic [62:0] bid_book[TABLE_ENTRIES];
  logic [62:0] ask_book[TABLE_ENTRIES];
  logic [63:0] last_ts[TABLE_ENTRIES];
  logic [1:0]  have_side[TABLE_ENTRIES];
  int unsigned n_instr = 0;
  logic [62:0] notional_cap = MASK63;

  tobqc_pkg::in_item_t  pending_items[$];
  tobqc_pkg::out_item_t expected_quotes[$];
  int unsigned sender_idle_pct = 15;
  logic hold_sender = 1'b0;
  logic took_q = 1'b0;
  int unsigned error_count = 0;
  longint unsigned cycle_count = 0;
  logic [63:0] key_pool[8];

  function automatic int find_instr(logic [63:0] key);
    for (int i = 0; i < n_instr; i++) begin
      if (inst_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // apply one item to the table copy and return the result it must give
  function automatic tobqc_pkg::out_item_t apply_item(tobqc_pkg::in_item_t it);
    tobqc_pkg::out_item_t r;
    int idx;
    logic [62:0] b;
    logic [62:0] a;
    logic [62:0] spr;
    r = '0;
    r.status = tobqc_pkg::ST_APPLIED;
    if (it.cmd == tobqc_pkg::CMD_BOOK || it.cmd == tobqc_pkg::CMD_TICK) begin
      if (it.instr_key == 0 || it.timestamp == 0 ||
          (it.cmd == tobqc_pkg::CMD_BOOK && it.side > tobqc_pkg::SIDE_SELL)) begin
        r.status = tobqc_pkg::ST_BAD;
      end else if ((it.cmd == tobqc_pkg::CMD_BOOK && (it.level_count <= 0 ||
                    it.price <= 0 || it.quantity <= 0 || it.order_count <= 0)) ||
                   (it.cmd == tobqc_pkg::CMD_TICK && (it.tick_bid <= 0 ||
                    it.tick_ask <= 0 || it.tick_last <= 0 || it.volume < 0))) begin
        r.status = tobqc_pkg::ST_FILTERED;
      end else begin
        idx = find_instr(it.instr_key);
        if (idx < 0 && n_instr < TABLE_ENTRIES) begin
          idx = n_instr;
          inst_keys[idx] = it.instr_key;
          bid_book[idx] = '0;
          ask_book[idx] = '0;
          last_ts[idx] = '0;
          have_side[idx] = '0;
          n_instr++;
        end
        if (idx < 0) begin
          r.status = tobqc_pkg::ST_FULL;
        end else if (last_ts[idx] != 0 && it.timestamp <= last_ts[idx]) begin
          r.status = tobqc_pkg::ST_STALE;
        end else if (it.cmd == tobqc_pkg::CMD_TICK) begin
          bid_book[idx] = it.tick_bid[62:0];
          ask_book[idx] = it.tick_ask[62:0];
          have_side[idx] = 2'b11;
          last_ts[idx] = it.timestamp;
        end else if (it.side == tobqc_pkg::SIDE_BUY) begin
          if (!have_side[idx][0] || it.price[62:0] > bid_book[idx]) begin
            bid_book[idx] = it.price[62:0];
            have_side[idx][0] = 1'b1;
            last_ts[idx] = it.timestamp;
          end else begin
            r.status = tobqc_pkg::ST_STALE;
          end
        end else begin
          if (!have_side[idx][1] || it.price[62:0] < ask_book[idx]) begin
            ask_book[idx] = it.price[62:0];
            have_side[idx][1] = 1'b1;
            last_ts[idx] = it.timestamp;
          end else begin
            r.status = tobqc_pkg::ST_STALE;
          end
        end
      end
    end else if (it.cmd == tobqc_pkg::CMD_QUERY) begin
      idx = find_instr(it.instr_key);
      if (idx < 0) begin
        r.status = tobqc_pkg::ST_NOT_FOUND;
      end else begin
        b = bid_book[idx];
        a = ask_book[idx];
        r.bid_out = b;
        r.ask_out = a;
        r.ts_out = last_ts[idx];
        if (have_side[idx] == 2'b11 && b > 0 && a > 0 && a >= b &&
            b <= notional_cap && a <= notional_cap) begin
          spr = a - b;
          r.quote_valid = 1'b1;
          r.mid_out = b + (spr >> 1);
          r.spread_out = spr;
        end
      end
    end else begin
      r.status = tobqc_pkg::ST_BAD;
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly small positive values, sometimes edge or fully random
  function automatic logic [63:0] rand_price();
    case ($urandom_range(0, 9))
      0: return rand64();
      1: return 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 1) ? 64'd0 : 64'h8000_0000_0000_0000;
      default: return 64'(1 + $urandom_range(0, 1000));
    endcase
  endfunction

  function automatic tobqc_pkg::in_item_t rand_item(logic [63:0] ts);
    tobqc_pkg::in_item_t it;
    it.cmd = $urandom_range(0, 19) == 0 ? tobqc_pkg::CMD_BAD
                                        : tobqc_pkg::cmd_e'($urandom_range(0, 2));
    it.instr_key = $urandom_range(0, 29) == 0 ? ($urandom_range(0, 1) ? 64'd0 : rand64())
                                              : key_pool[$urandom_range(0, 7)];
    it.side = $urandom_range(0, 11) == 0 ? 2'($urandom_range(2, 3))
                                         : 2'($urandom_range(0, 1));
    it.level_count = $urandom_range(0, 14) == 0 ? $urandom() : $urandom_range(1, 20);
    it.price = rand_price();
    it.quantity = $urandom_range(0, 14) == 0 ? rand64() : 64'($urandom_range(1, 500));
    it.order_count = $urandom_range(0, 14) == 0 ? rand64() : 64'($urandom_range(1, 50));
    it.tick_bid = rand_price();
    it.tick_ask = $urandom_range(0, 2) == 0 ? rand_price() : it.tick_bid + $urandom_range(0, 9);
    it.tick_last = $urandom_range(0, 14) == 0 ? rand64() : 64'($urandom_range(1, 900));
    it.volume = $urandom_range(0, 9) == 0 ? rand64() : 64'($urandom_range(0, 900));
    it.timestamp = $urandom_range(0, 24) == 0 ? ($urandom_range(0, 1) ? 64'd0 : rand64())
                                              : ts - $urandom_range(0, 2);
    return it;
  endfunction

  function automatic tobqc_pkg::in_item_t book_item(tobqc_pkg::cmd_e c, logic [63:0] key,
                                                    logic [1:0] sd, logic [63:0] px,
                                                    logic [63:0] ts);
    tobqc_pkg::in_item_t it;
    it = '0;
    it.cmd = c;
    it.instr_key = key;
    it.side = sd;
    it.level_count = 1;
    it.price = px;
    it.quantity = 1;
    it.order_count = 1;
    it.tick_bid = px;
    it.tick_ask = px + 2;
    it.tick_last = px;
    it.timestamp = ts;
    return it;
  endfunction

  // driver: a transfer happens on a rising edge with start high and busy low
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took_q) begin
        // the item in flight was taken at the last rising edge
        void'(pending_items.pop_front());
      end
      if (pending_items.size() != 0 && !hold_sender &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        start_i <= 1'b1;
        item_i <= pending_items[0];
      end else begin
        start_i <= 1'b0;
        item_i <= '0;
      end
    end
  end

  // predict on the accepted transfer, check each strobed result
  always @(posedge clk_i) begin
    tobqc_pkg::out_item_t exp_r;
    cycle_count <= cycle_count + 1;
    took_q <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      expected_quotes.push_back(apply_item(item_i));
    end
    if (rst_ni && done_o) begin
      if (expected_quotes.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        error_count++;
      end else begin
        exp_r = expected_quotes.pop_front();
        if (result_o !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, result_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("top_of_book_quote_cache_tb failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || start_i) @(posedge clk_i);
    while (expected_quotes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cap(logic [62:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    notional_cap = v;
  endtask

  initial begin
    logic [63:0] ts_now;
    for (int i = 0; i < 8; i++) key_pool[i] = rand64() | 64'd1;
    key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool[1] = 64'd1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every command and every special case but a full table
    pending_items.push_back(book_item(tobqc_pkg::CMD_QUERY, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 1, 1)); // miss
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, 64'd0,
                                      tobqc_pkg::SIDE_BUY, 5, 1)); // empty key
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 5, 0)); // empty ts
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0], 2'd2, 5, 9)); // bad side
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0], 2'd3, -5, 9));
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, -5, 9)); // filtered
    pending_items.push_back(book_item(tobqc_pkg::CMD_BAD, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 5, 9));
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 100, 10));
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 90, 11)); // not better
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 120, 10)); // stale
    pending_items.push_back(book_item(tobqc_pkg::CMD_QUERY, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 1, 1)); // one side
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0],
                                      tobqc_pkg::SIDE_SELL, 107, 12));
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[0],
                                      tobqc_pkg::SIDE_SELL, 108, 13));
    pending_items.push_back(book_item(tobqc_pkg::CMD_QUERY, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 1, 1));
    pending_items.push_back(book_item(tobqc_pkg::CMD_TICK, key_pool[1], tobqc_pkg::SIDE_BUY,
                                      64'h7FFF_FFFF_FFFF_FFFD, 64'hFFFF_FFFF_FFFF_FFFF));
    pending_items.push_back(book_item(tobqc_pkg::CMD_QUERY, key_pool[1],
                                      tobqc_pkg::SIDE_BUY, 1, 1));
    pending_items.push_back(book_item(tobqc_pkg::CMD_TICK, key_pool[1],
                                      tobqc_pkg::SIDE_BUY, 5, 64'd77)); // stale
    pending_items.push_back(book_item(tobqc_pkg::CMD_TICK, key_pool[2],
                                      tobqc_pkg::SIDE_BUY, 0, 3)); // filtered
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[3],
                                      tobqc_pkg::SIDE_SELL, 50, 3));
    pending_items.push_back(book_item(tobqc_pkg::CMD_BOOK, key_pool[3],
                                      tobqc_pkg::SIDE_BUY, 60, 4)); // crossed
    pending_items.push_back(book_item(tobqc_pkg::CMD_QUERY, key_pool[3],
                                      tobqc_pkg::SIDE_BUY, 1, 1));
    wait_drained();

    // cap below the queried asks, then the extremes
    write_cap(63'd100);
    pending_items.push_back(book_item(tobqc_pkg::CMD_QUERY, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 1, 1));
    pending_items.push_back(book_item(tobqc_pkg::CMD_QUERY, key_pool[1],
                                      tobqc_pkg::SIDE_BUY, 1, 1));
    wait_drained();
    write_cap(63'd0);
    pending_items.push_back(book_item(tobqc_pkg::CMD_QUERY, key_pool[0],
                                      tobqc_pkg::SIDE_BUY, 1, 1));
    wait_drained();
    write_cap(MASK63);

    // random phases: sender idles lightly, then heavily, then never
    ts_now = 64'd100;
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = ph == 0 ? 15 : (ph == 1 ? 67 : 0);
      for (int n = 0; n < 39; n++) begin
        ts_now += $urandom_range(0, 3);
        pending_items.push_back(rand_item(ts_now));
        if (ph == 2 && n == 20) begin
          // hold the sender until every outstanding result is back
          while (pending_items.size() != 0 || start_i) @(posedge clk_i);
          hold_sender = 1'b1;
          while (expected_quotes.size() != 0) @(posedge clk_i);
          hold_sender = 1'b0;
        end
      end
      wait_drained();
      write_cap(ph == 0 ? 63'd500 : (ph == 1 ? 63'($urandom_range(1, 1000)) : MASK63));
    end

    if (error_count == 0) begin
      $display("top_of_book_quote_cache_tb passed");
    end else begin
      $display("top_of_book_quote_cache_tb failed");
    end
    $finish;
  end

endmodule
